[src/ws2812_pixel_serializer_unit_macros.svh]
// Assertion macros for the serializer checker.
`ifndef WS2812_PIXEL_SERIALIZER_UNIT_MACROS_SVH
`define WS2812_PIXEL_SERIALIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define WS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("serializer check failed");

// Next-cycle implication, sampled on aclk, off while in reset
`define WS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("serializer check failed");

`endif

[src/ws2812ps_pkg.sv]
// Types and constants shared by the WS2812 pixel serializer modules.
`timescale 1ns / 1ps
`default_nettype none

package ws2812ps_pkg;

    localparam int PERIOD_W    = 16;
    localparam int GAP_W       = 24;
    localparam int COLOR_W     = 24;
    localparam int COUNT_W     = 8;
    localparam int BIT_IDX_W   = 5;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    // First bit sent of each color word
    localparam logic [BIT_IDX_W-1:0] TOP_BIT = 5'd23;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_GAP  = 8'd3;

    // Reset timing: 1.25 us bit at 100 MHz, plus the zero and one high times and the frame gap
    localparam logic [PERIOD_W-1:0] RST_BIT_PERIOD = 16'd125;
    localparam logic [PERIOD_W-1:0] RST_ZERO_HIGH  = 16'd18;
    localparam logic [PERIOD_W-1:0] RST_ONE_HIGH   = 16'd107;
    localparam logic [GAP_W-1:0]    RST_FRAME_GAP  = 24'd50000;

    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period_ticks;
        logic [PERIOD_W-1:0] zero_high_ticks;
        logic [PERIOD_W-1:0] one_high_ticks;
        logic [GAP_W-1:0]    frame_gap_ticks;
    } timing_cfg_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } tick_result_t;

endpackage

`default_nettype wire

[src/ws2812ps_cfg_regs.sv]
// Timing configuration registers of the WS2812 pixel serializer.
`timescale 1ns / 1ps
`default_nettype none

module ws2812ps_cfg_regs (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ws2812ps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ws2812ps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ws2812ps_pkg::timing_cfg_t                  timing
);

    ws2812ps_pkg::timing_cfg_t timing_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign timing    = timing_reg;

    // Register file; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.bit_period_ticks <= ws2812ps_pkg::RST_BIT_PERIOD;
            timing_reg.zero_high_ticks  <= ws2812ps_pkg::RST_ZERO_HIGH;
            timing_reg.one_high_ticks   <= ws2812ps_pkg::RST_ONE_HIGH;
            timing_reg.frame_gap_ticks  <= ws2812ps_pkg::RST_FRAME_GAP;
        end else if (cfg_valid) begin
            case (cfg_index)
                ws2812ps_pkg::REG_BIT_PERIOD: begin
                    timing_reg.bit_period_ticks <= cfg_data[ws2812ps_pkg::PERIOD_W-1:0];
                end
                ws2812ps_pkg::REG_ZERO_HIGH: begin
                    timing_reg.zero_high_ticks <= cfg_data[ws2812ps_pkg::PERIOD_W-1:0];
                end
                ws2812ps_pkg::REG_ONE_HIGH: begin
                    timing_reg.one_high_ticks <= cfg_data[ws2812ps_pkg::PERIOD_W-1:0];
                end
                ws2812ps_pkg::REG_FRAME_GAP: begin
                    timing_reg.frame_gap_ticks <= cfg_data[ws2812ps_pkg::GAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[src/ws2812ps_engine.sv]
// Frame state and per-tick next-state logic of the WS2812 pixel serializer.
`timescale 1ns / 1ps
`default_nettype none

module ws2812ps_engine (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                step_en,
    input  wire logic                                kind,
    input  wire logic [ws2812ps_pkg::COLOR_W-1:0]    color,
    input  wire logic [ws2812ps_pkg::COUNT_W-1:0]    pixel_count,
    input  ws2812ps_pkg::timing_cfg_t                timing,
    output ws2812ps_pkg::tick_result_t               result
);

    localparam int PW = ws2812ps_pkg::PERIOD_W;
    localparam int GW = ws2812ps_pkg::GAP_W;
    localparam int CW = ws2812ps_pkg::COLOR_W;
    localparam int NW = ws2812ps_pkg::COUNT_W;
    localparam int BW = ws2812ps_pkg::BIT_IDX_W;

    logic          sending_reg,       sending_next;
    logic [CW-1:0] active_color_reg,  active_color_next;
    logic [NW-1:0] pixels_left_reg,   pixels_left_next;
    logic [BW-1:0] bit_index_reg,     bit_index_next;
    logic [PW-1:0] period_counter_reg, period_counter_next;
    logic [GW-1:0] gap_counter_reg,   gap_counter_next;
    logic          pending_valid_reg, pending_valid_next;
    logic [CW-1:0] pending_color_reg, pending_color_next;
    logic [NW-1:0] pending_count_reg, pending_count_next;

    // One tick: capture request, launch if idle, then run bit or gap timing
    always_comb begin
        logic          cur_bit;
        logic [PW-1:0] high_ticks;
        logic          period_end;

        sending_next        = sending_reg;
        active_color_next   = active_color_reg;
        pixels_left_next    = pixels_left_reg;
        bit_index_next      = bit_index_reg;
        period_counter_next = period_counter_reg;
        gap_counter_next    = gap_counter_reg;
        pending_valid_next  = pending_valid_reg;
        pending_color_next  = pending_color_reg;
        pending_count_next  = pending_count_reg;
        result              = '0;

        // Single pending slot; a request while full is dropped
        if (kind && !pending_valid_reg) begin
            pending_valid_next = 1'b1;
            pending_color_next = color;
            pending_count_next = pixel_count;
        end

        // Launch from the slot when neither sending nor in the gap
        if (!sending_reg && gap_counter_reg == '0 && pending_valid_next) begin
            pending_valid_next = 1'b0;
            if (pending_count_next == '0) begin
                gap_counter_next = timing.frame_gap_ticks;
            end else begin
                sending_next        = 1'b1;
                active_color_next   = pending_color_next;
                pixels_left_next    = pending_count_next;
                bit_index_next      = ws2812ps_pkg::TOP_BIT;
                period_counter_next = '0;
            end
        end

        cur_bit    = active_color_next[bit_index_next];
        high_ticks = cur_bit ? timing.one_high_ticks : timing.zero_high_ticks;
        period_end = ({1'b0, period_counter_next} + {{PW{1'b0}}, 1'b1})
                     >= {1'b0, timing.bit_period_ticks};

        if (sending_next) begin
            result.line_level = (period_counter_next < high_ticks);
            result.busy_res   = 1'b1;
            if (period_end) begin
                period_counter_next = '0;
                if (bit_index_next == '0) begin
                    bit_index_next   = ws2812ps_pkg::TOP_BIT;
                    pixels_left_next = pixels_left_next - 1'b1;
                    if (pixels_left_next == '0) begin
                        sending_next      = 1'b0;
                        result.frame_done = 1'b1;
                        gap_counter_next  = timing.frame_gap_ticks;
                    end
                end else begin
                    bit_index_next = bit_index_next - 1'b1;
                end
            end else begin
                period_counter_next = period_counter_next + 1'b1;
            end
        end else if (gap_counter_next != '0) begin
            result.busy_res  = 1'b1;
            gap_counter_next = gap_counter_next - 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg        <= 1'b0;
            bit_index_reg      <= ws2812ps_pkg::TOP_BIT;
            period_counter_reg <= '0;
            gap_counter_reg    <= '0;
            pending_valid_reg  <= 1'b0;
        end else if (step_en) begin
            sending_reg        <= sending_next;
            bit_index_reg      <= bit_index_next;
            period_counter_reg <= period_counter_next;
            gap_counter_reg    <= gap_counter_next;
            pending_valid_reg  <= pending_valid_next;
        end
    end

    // Payload state, only read once qualified by the control state
    always_ff @(posedge aclk) begin
        if (step_en) begin
            active_color_reg  <= active_color_next;
            pixels_left_reg   <= pixels_left_next;
            pending_color_reg <= pending_color_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

`default_nettype wire

[src/ws2812_pixel_serializer_unit.sv]
// Top level of the WS2812 pixel serializer: stream ports, input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one tick of the LED line timing and yields exactly one result
// word (line level, busy, frame done). The block takes one word per cycle while the
// result side keeps up: the word is held in an input register, one pass of the frame
// logic updates the serializer state, and the result lands in an output register.
// When m_tready is low the two registers fill and s_tready drops; the line timing
// only advances on words actually taken, so stalls stretch the timing. Users must
// write timing registers through the cfg port while no word is in flight (unchecked).
module ws2812_pixel_serializer_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [31:0]                          s_tdata,  // [23:0] color, [31:24] pixel_count
    input  wire logic                                 s_tuser,  // [0] kind
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [7:0]                                m_tdata,  // [0] line_level, [1] busy_res, rest 0
    output logic                                      m_tlast,  // frame_done
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ws2812ps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ws2812ps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = ws2812ps_pkg::COLOR_W;
    localparam int NW = ws2812ps_pkg::COUNT_W;

    ws2812ps_pkg::timing_cfg_t   timing;
    ws2812ps_pkg::tick_result_t  step_result;

    logic          in_valid_reg;
    logic          in_kind_reg;
    logic [CW-1:0] in_color_reg;
    logic [NW-1:0] in_count_reg;
    logic          out_valid_reg;
    ws2812ps_pkg::tick_result_t out_result_reg;
    logic          advance;

    // Word moves from input to result register when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;

    ws2812ps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    ws2812ps_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .kind        (in_kind_reg),
        .color       (in_color_reg),
        .pixel_count (in_count_reg),
        .timing      (timing),
        .result      (step_result)
    );

    // Input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg  <= s_tuser;
            in_color_reg <= s_tdata[CW-1:0];
            in_count_reg <= s_tdata[CW+NW-1:CW];
        end
    end

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_result_reg.busy_res, out_result_reg.line_level};
    assign m_tlast  = out_result_reg.frame_done;

endmodule

`default_nettype wire

[src/ws2812ps_checker.sv]
// Port-level checks for the WS2812 pixel serializer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "ws2812_pixel_serializer_unit_macros.svh"

module ws2812ps_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // A stalled result word holds
    `WS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Frame end is only reported while busy
    `WS_ASSERT_NOW(a_done_busy, m_tvalid && m_tlast, m_tdata[1])

    // The line is only driven high while busy
    `WS_ASSERT_NOW(a_line_busy, m_tvalid && m_tdata[0], m_tdata[1])

    // Input back-pressure only comes from a stalled, full result register
    `WS_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)

endmodule

bind ws2812_pixel_serializer_unit ws2812ps_checker u_ws2812ps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/ws2812_pixel_serializer_unit_tb.sv]
// Testbench for the WS2812 pixel serializer: stream stimulus, tick-accurate line predictor.
`timescale 1ns / 1ps

module ws2812_pixel_serializer_unit_tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 200;

    localparam int COLOR_W     = ws2812ps_pkg::COLOR_W;
    localparam int COUNT_W     = ws2812ps_pkg::COUNT_W;
    localparam int PERIOD_W    = ws2812ps_pkg::PERIOD_W;
    localparam int GAP_W       = ws2812ps_pkg::GAP_W;
    localparam int BIT_IDX_W   = ws2812ps_pkg::BIT_IDX_W;
    localparam int CFG_INDEX_W = ws2812ps_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = ws2812ps_pkg::CFG_DATA_W;

    // One input word: a tick, optionally carrying a frame request
    typedef struct {
        logic               kind;
        logic [COLOR_W-1:0] color;
        logic [COUNT_W-1:0] count;
    } tick_word_t;

    logic aclk     = 1'b0;
    logic aresetn  = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata  = '0;  // [23:0] color, [31:24] pixel_count
    logic                   s_tuser  = 1'b0; // [0] kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;        // [0] line_level, [1] busy_res
    logic                   m_tlast;        // frame_done
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    ws2812_pixel_serializer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Words waiting to be sent and line levels waiting to come out
    tick_word_t                 tick_q[$];
    ws2812ps_pkg::tick_result_t level_q[$];

    // Predictor copy of timing registers and serializer state
    ws2812ps_pkg::timing_cfg_t timing_now = '{ws2812ps_pkg::RST_BIT_PERIOD,
                                              ws2812ps_pkg::RST_ZERO_HIGH,
                                              ws2812ps_pkg::RST_ONE_HIGH,
                                              ws2812ps_pkg::RST_FRAME_GAP};
    logic                 ser_sending = 1'b0;
    logic [COLOR_W-1:0]   ser_color   = '0;
    logic [COUNT_W-1:0]   ser_pixels  = '0;
    logic [BIT_IDX_W-1:0] ser_bit     = ws2812ps_pkg::TOP_BIT;
    logic [PERIOD_W-1:0]  ser_phase   = '0;
    logic [GAP_W-1:0]     ser_gap     = '0;
    logic                 held_valid  = 1'b0;
    logic [COLOR_W-1:0]   held_color  = '0;
    logic [COUNT_W-1:0]   held_count  = '0;

    // Pacing controls set per phase
    logic s_idle_en = 1'b1;
    logic m_idle_en = 1'b1;
    int   hold_reqs   = 0;
    int   hold_served = 0;
    int   mismatches  = 0;

    // One tick of the line: take a request, launch if idle, form the output, advance
    function automatic ws2812ps_pkg::tick_result_t advance_line(
            input logic kind,
            input logic [COLOR_W-1:0] color,
            input logic [COUNT_W-1:0] count);
        ws2812ps_pkg::tick_result_t res;
        logic [PERIOD_W-1:0]        high_t;
        res = '0;
        if (kind && !held_valid) begin
            held_valid = 1'b1;
            held_color = color;
            held_count = count;
        end
        if (!ser_sending && ser_gap == '0 && held_valid) begin
            held_valid = 1'b0;
            if (held_count == '0) begin
                // empty frame still opens the guard gap
                ser_gap = timing_now.frame_gap_ticks;
            end else begin
                ser_sending = 1'b1;
                ser_color   = held_color;
                ser_pixels  = held_count;
                ser_bit     = ws2812ps_pkg::TOP_BIT;
                ser_phase   = '0;
            end
        end
        if (ser_sending) begin
            high_t = ser_color[ser_bit] ? timing_now.one_high_ticks
                                        : timing_now.zero_high_ticks;
            res.line_level = (ser_phase < high_t);
            res.busy_res   = 1'b1;
            if ({1'b0, ser_phase} + 17'd1 >= {1'b0, timing_now.bit_period_ticks}) begin
                ser_phase = '0;
                if (ser_bit == '0) begin
                    ser_bit    = ws2812ps_pkg::TOP_BIT;
                    ser_pixels = ser_pixels - 1'b1;
                    if (ser_pixels == '0) begin
                        ser_sending    = 1'b0;
                        res.frame_done = 1'b1;
                        ser_gap        = timing_now.frame_gap_ticks;
                    end
                end else begin
                    ser_bit = ser_bit - 1'b1;
                end
            end else begin
                ser_phase = ser_phase + 1'b1;
            end
        end else if (ser_gap != '0) begin
            res.busy_res = 1'b1;
            ser_gap      = ser_gap - 1'b1;
        end
        return res;
    endfunction

    // Input driver: offers queued words, random gap after each one when s_idle_en is set
    tick_word_t offered;
    int         send_wait = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready)
                level_q.push_back(advance_line(offered.kind, offered.color, offered.count));
            if (!s_tvalid || s_tready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    offered = tick_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered.count, offered.color};
                    s_tuser  <= offered.kind;
                    send_wait = s_idle_en ? $urandom_range(0, 13) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stalls when m_idle_en is set, long hold-off on request, field checks
    ws2812ps_pkg::tick_result_t want;
    int                         stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (level_q.size() == 0) begin
                    $error("result word with no expectation waiting");
                    mismatches++;
                end else begin
                    want = level_q.pop_front();
                    if (m_tdata[0] !== want.line_level) begin
                        $error("line_level: expected %0b, got %0b", want.line_level, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[1] !== want.busy_res) begin
                        $error("busy_res: expected %0b, got %0b", want.busy_res, m_tdata[1]);
                        mismatches++;
                    end
                    if (m_tlast !== want.frame_done) begin
                        $error("frame_done: expected %0b, got %0b", want.frame_done, m_tlast);
                        mismatches++;
                    end
                end
                stall_left = m_idle_en ? $urandom_range(0, 13) : 0;
            end
            if (hold_served != hold_reqs) begin
                hold_served++;
                stall_left = stall_left + HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no word moving on any channel
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // One register write; valid stays up for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            ws2812ps_pkg::REG_BIT_PERIOD:
                timing_now.bit_period_ticks = val[PERIOD_W-1:0];
            ws2812ps_pkg::REG_ZERO_HIGH:
                timing_now.zero_high_ticks  = val[PERIOD_W-1:0];
            ws2812ps_pkg::REG_ONE_HIGH:
                timing_now.one_high_ticks   = val[PERIOD_W-1:0];
            ws2812ps_pkg::REG_FRAME_GAP:
                timing_now.frame_gap_ticks  = val[GAP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_timing(input logic [PERIOD_W-1:0] period,
                                  input logic [PERIOD_W-1:0] zero_t,
                                  input logic [PERIOD_W-1:0] one_t,
                                  input logic [GAP_W-1:0] gap);
        write_reg(ws2812ps_pkg::REG_BIT_PERIOD, CFG_DATA_W'(period));
        write_reg(ws2812ps_pkg::REG_ZERO_HIGH, CFG_DATA_W'(zero_t));
        write_reg(ws2812ps_pkg::REG_ONE_HIGH, CFG_DATA_W'(one_t));
        write_reg(ws2812ps_pkg::REG_FRAME_GAP, gap);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every word is taken and every result checked, then let the pipe settle;
    // checked on the falling edge so the driver's updates of the same edge are seen
    task automatic drain_line();
        while (tick_q.size() != 0 || s_tvalid || level_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_tick(input logic kind, input logic [COLOR_W-1:0] color,
                             input logic [COUNT_W-1:0] count);
        tick_word_t w;
        w.kind  = kind;
        w.color = color;
        w.count = count;
        tick_q.push_back(w);
    endtask

    // Plain ticks with random ignored fields
    task automatic push_plain(input int n);
        for (int i = 0; i < n; i++)
            push_tick(1'b0, COLOR_W'($urandom), COUNT_W'($urandom));
    endtask

    // Mostly plain ticks, a share of requests with short frames
    task automatic push_random(input int n, input int req_pct, input int max_pixels);
        logic kind;
        for (int i = 0; i < n; i++) begin
            kind = ($urandom_range(0, 99) < req_pct);
            push_tick(kind, COLOR_W'($urandom),
                      kind ? COUNT_W'($urandom_range(0, max_pixels)) : COUNT_W'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timing: a frame starts, a second request waits, a third is dropped
        push_tick(1'b0, '0, '0);
        push_tick(1'b0, 24'hFFFFFF, 8'hFF);
        push_tick(1'b1, 24'h800001, 8'd1);
        push_tick(1'b1, 24'h123456, 8'd2);
        push_tick(1'b1, 24'hFFFFFF, 8'd255);
        push_plain(3);
        drain_line();

        // short period, one-time longer than period, no gap; an empty frame, then a one-pixel frame
        program_timing(16'd2, 16'd1, 16'd3, 24'd0);
        push_plain(40);
        push_tick(1'b1, 24'h000000, 8'd0);
        push_plain(60);
        push_tick(1'b1, 24'h5A5A5A, 8'd1);
        push_plain(60);
        drain_line();

        // longest period, zero-time equal to period, short one-time
        program_timing(16'hFFFF, 16'hFFFF, 16'd1, 24'd3);
        push_tick(1'b1, 24'h00FF00, 8'd1);
        push_plain(100);
        drain_line();

        // random frames with short gaps
        program_timing(16'd3, 16'd1, 16'd2, 24'd5);
        push_random(150, 4, 2);
        drain_line();

        // no idling on either side
        s_idle_en = 1'b0;
        m_idle_en = 1'b0;
        program_timing(16'd2, 16'd1, 16'd1, 24'd0);
        push_random(100, 5, 2);
        drain_line();

        // receiver holds off long enough for the block to stall its input
        s_idle_en = 1'b1;
        m_idle_en = 1'b1;
        program_timing(16'd4, 16'd2, 16'd3, 24'd1);
        hold_reqs++;
        push_random(100, 4, 1);
        drain_line();

        // longest gap: the block stays busy, one further request waits in the slot, the rest are dropped
        program_timing(16'd2, 16'd1, 16'd1, 24'hFFFFFF);
        push_random(60, 5, 1);
        push_tick(1'b1, COLOR_W'($urandom), 8'd255);
        push_tick(1'b1, COLOR_W'($urandom), 8'd0);
        push_random(40, 10, 255);
        drain_line();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/ws2812ps_pkg.sv
src/ws2812ps_cfg_regs.sv
src/ws2812ps_engine.sv
src/ws2812_pixel_serializer_unit.sv
src/ws2812ps_checker.sv
tb/ws2812_pixel_serializer_unit_tb.sv
